FILE: design/ricd_pkg.sv
// Shared constants, codes and types for the random interval countdown timer.
`default_nettype none

package ricd_pkg;

    localparam int CNT_W   = 16;
    localparam int TS_W    = 32;
    localparam int CMD_W   = 3;
    localparam int EV_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 40;

    localparam int DEF_INTERVAL_LIMIT = 65535;
    localparam int DEF_INTERVAL_FLOOR = 1;

    localparam logic [CNT_W-1:0] MIN_RESET = 16'd0;
    localparam logic [CNT_W-1:0] MAX_RESET = 16'd60;

    // one remainder bit per cycle
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_STARTED  = 2'd1;
    localparam logic [EV_W-1:0] EV_RESUMED  = 2'd2;
    localparam logic [EV_W-1:0] EV_FINISHED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] min_interval;
        logic [CNT_W-1:0] max_interval;
        logic             repeat_enable;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [CNT_W-1:0] interval;
        logic             running;
        logic [CNT_W-1:0] remaining;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

FILE: design/ricd_cfg.sv
// Configuration registers with min/max clamping on write.
`default_nettype none

module ricd_cfg #(
    parameter int INTERVAL_LIMIT = ricd_pkg::DEF_INTERVAL_LIMIT,
    parameter int INTERVAL_FLOOR = ricd_pkg::DEF_INTERVAL_FLOOR
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [ricd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [ricd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output ricd_pkg::t_cfg                       o_cfg
);
    import ricd_pkg::*;

    localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(INTERVAL_LIMIT);
    localparam logic [CNT_W-1:0] LIMIT_M1 = CNT_W'(INTERVAL_LIMIT - 1);
    localparam logic [CNT_W-1:0] FLOOR    = CNT_W'(INTERVAL_FLOOR);

    t_cfg             r_cfg, n_cfg;
    logic [CNT_W-1:0] w_min_v, w_max_v;

    always_comb begin
        n_cfg   = r_cfg;
        w_min_v = i_cfg_wdata;
        if (w_min_v > LIMIT) begin
            w_min_v = LIMIT_M1;
        end
        if (w_min_v > r_cfg.max_interval) begin
            w_min_v = r_cfg.max_interval;
        end

        w_max_v = i_cfg_wdata;
        if (w_max_v < FLOOR) begin
            w_max_v = FLOOR;
        end
        if (w_max_v > LIMIT) begin
            w_max_v = LIMIT;
        end
        if (w_max_v < r_cfg.min_interval) begin
            w_max_v = r_cfg.min_interval;
        end
        // keep a non-empty span unless already at the top
        if (w_max_v == r_cfg.min_interval && w_max_v != {CNT_W{1'b1}}) begin
            w_max_v = w_max_v + 1'b1;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN:    n_cfg.min_interval  = w_min_v;
                REG_MAX:    n_cfg.max_interval  = w_max_v;
                REG_REPEAT: n_cfg.repeat_enable = i_cfg_wdata[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval  <= MIN_RESET;
            r_cfg.max_interval  <= MAX_RESET;
            r_cfg.repeat_enable <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/ricd_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module ricd_mod (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [ricd_pkg::CNT_W-1:0]   i_dividend,
    input  wire  [ricd_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [ricd_pkg::CNT_W-1:0]   o_rem
);
    import ricd_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_div, n_div;
    logic [CNT_W:0]       w_shift;
    logic [CNT_W:0]       w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[CNT_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[CNT_W-2:0], 1'b0};
            n_rem = (w_shift >= {1'b0, r_div}) ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    // zero divisor means an empty range: term is 0
    assign o_rem  = (r_div == '0) ? '0 : r_rem;

endmodule

`default_nettype wire

FILE: design/random_interval_countdown_timer.sv
// A start runs the 16 serial remainder steps, then latches the interval and loads the output;
// a resume or finish latches its result on acceptance and then loads the output; a repeat
// finish starts a new draw as its result is loaded. Requests are taken only while idle, so a
// start, resume or finish holds off later requests, as does a result waiting on m_axis_tready.
// Reset (i_rst_n, synchronous, active low): timer stopped, count and pause stamp cleared,
// min 0, max 60, repeat off, output empty.
`default_nettype none

module random_interval_countdown_timer #(
    parameter int INTERVAL_LIMIT = ricd_pkg::DEF_INTERVAL_LIMIT,
    parameter int INTERVAL_FLOOR = ricd_pkg::DEF_INTERVAL_FLOOR
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [ricd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [ricd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [ricd_pkg::S_DATA_W-1:0]        s_axis_tdata,  // timestamp[31:0], random_value[47:32]
    input  wire  [ricd_pkg::CMD_W-1:0]           s_axis_tuser,  // cmd[2:0]
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [ricd_pkg::M_DATA_W-1:0]        m_axis_tdata,  // interval[15:0], running[16],
                                                                // remaining[32:17], zero[39:33]
    output logic [ricd_pkg::EV_W-1:0]            m_axis_tuser,  // event_res[1:0]
    output logic                                 m_axis_tlast
);
    import ricd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_EMIT
    } t_state;

    t_cfg             w_cfg;
    t_state           r_state, n_state;
    logic             r_run, n_run;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TS_W-1:0]  r_stamp, n_stamp;
    logic [CNT_W-1:0] r_rnd, n_rnd;
    logic             r_chain, n_chain;
    t_result          r_pend, n_pend;
    t_result          r_out, n_out;
    logic             r_ovalid, n_ovalid;

    logic             w_accept, w_out_free;
    logic [TS_W-1:0]  w_ts;
    logic [CNT_W-1:0] w_rnd_in;
    logic [CMD_W-1:0] w_cmd;
    logic [CNT_W-1:0] w_delta, w_span, w_term, w_dividend;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_interval;
    logic             w_div_start, w_div_done;

    ricd_cfg #(
        .INTERVAL_LIMIT (INTERVAL_LIMIT),
        .INTERVAL_FLOOR (INTERVAL_FLOOR)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ricd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_span),
        .o_done     (w_div_done),
        .o_rem      (w_term)
    );

    assign w_ts       = s_axis_tdata[TS_W-1:0];
    assign w_rnd_in   = s_axis_tdata[TS_W +: CNT_W];
    assign w_cmd      = s_axis_tuser;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_delta    = w_ts[CNT_W-1:0] - r_stamp[CNT_W-1:0];
    assign w_span     = (w_cfg.max_interval > w_cfg.min_interval)
                      ? (w_cfg.max_interval - w_cfg.min_interval) : '0;
    assign w_dividend = (r_state == S_IDLE) ? w_rnd_in : r_rnd;
    assign w_sum      = {1'b0, w_cfg.min_interval} + {1'b0, w_term} + (CNT_W+1)'(1);
    assign w_interval = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];

    assign w_div_start = (r_state == S_IDLE && w_accept && w_cmd == CMD_START)
                      || (r_state == S_EMIT && w_out_free && r_chain);

    always_comb begin
        n_state  = r_state;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_stamp  = r_stamp;
        n_rnd    = r_rnd;
        n_chain  = r_chain;
        n_pend   = r_pend;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rnd = w_rnd_in;
                    case (w_cmd)
                        CMD_START: begin
                            n_state = S_DRAW;
                        end
                        CMD_TICK: begin
                            if (r_run) begin
                                if (r_cnt != '0) begin
                                    n_cnt = r_cnt - 1'b1;
                                end else begin
                                    n_run            = 1'b0;
                                    n_pend.event_res = EV_FINISHED;
                                    n_pend.interval  = '0;
                                    n_pend.running   = 1'b0;
                                    n_pend.remaining = r_cnt;
                                    n_pend.last      = !w_cfg.repeat_enable;
                                    n_chain          = w_cfg.repeat_enable;
                                    n_state          = S_EMIT;
                                end
                            end
                        end
                        CMD_PAUSE: begin
                            if (r_run && w_ts != '0) begin
                                n_stamp = w_ts;
                            end
                        end
                        CMD_RESUME: begin
                            if (r_run && w_ts != '0 && w_ts >= r_stamp) begin
                                // overshoot leaves a count of one, not a wrap
                                n_cnt = (w_delta > r_cnt) ? CNT_W'(1) : (r_cnt - w_delta);
                                n_pend.event_res = EV_RESUMED;
                                n_pend.interval  = n_cnt;
                                n_pend.running   = 1'b1;
                                n_pend.remaining = n_cnt;
                                n_pend.last      = 1'b1;
                                n_chain          = 1'b0;
                                n_state          = S_EMIT;
                            end
                        end
                        CMD_STOP: begin
                            n_run = 1'b0;
                        end
                        default: begin
                            n_run = r_run;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (w_div_done) begin
                    n_run            = 1'b1;
                    n_cnt            = w_interval;
                    n_pend.event_res = EV_STARTED;
                    n_pend.interval  = w_interval;
                    n_pend.running   = 1'b1;
                    n_pend.remaining = w_interval;
                    n_pend.last      = 1'b1;
                    n_chain          = 1'b0;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = r_chain ? S_DRAW : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_cnt    <= '0;
            r_stamp  <= '0;
            r_chain  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_cnt    <= n_cnt;
            r_stamp  <= n_stamp;
            r_chain  <= n_chain;
            r_ovalid <= n_ovalid;
        end
        r_rnd  <= n_rnd;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {(M_DATA_W - 2*CNT_W - 1)'(0), r_out.remaining, r_out.running,
                            r_out.interval};

endmodule

`default_nettype wire
